@@ design/nnpo_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nnpo_pkg
// shared constants and controller/datapath handshake types for the
// nearest neighbour point orderer
// ----------------------------------------------------------------------------
package nnpo_pkg;

  localparam int unsigned MAX_POINTS_DEF  = 64;
  localparam int unsigned COORD_WIDTH_DEF = 24;

  // width of the source index field on the result stream
  localparam int unsigned SRC_IDX_W = 6;

  // configuration register map
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_START_X = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Y = 1'b1;

  typedef struct packed {
    logic load;        // store the accepted point
    logic start_pass;  // clear visited marks, move to start position
    logic issue;       // read one stored point into the distance pipeline
    logic emit;        // hand the best point to the output register
    logic emit_last;   // emitted point closes the run
  } nnpo_cmd_t;

  typedef struct packed {
    logic pipe_busy;   // distance pipeline still holds points
    logic out_free;    // output register can take a new result
  } nnpo_status_t;

endpackage
`default_nettype wire

@@ design/nearest_neighbour_point_orderer_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nearest_neighbour_point_orderer_core
// greedy nearest neighbour ordering of a loaded 2d point set
// ----------------------------------------------------------------------------
// load: one point per cycle, no results until the transaction with tlast
// ordering: each result takes one scan of the point memory through its single
//   read port plus pipeline drain
// no input is taken while a set is being ordered
// reset clears count, overflow flag, visited marks, start and current position
// point memory is not cleared, only written entries are ever read
module nearest_neighbour_point_orderer_core #(
  parameter int unsigned MAX_POINTS  = nnpo_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_WIDTH = nnpo_pkg::COORD_WIDTH_DEF,
  localparam int unsigned IN_DATA_W  = ((2 * COORD_WIDTH + 7) / 8) * 8,
  localparam int unsigned OUT_DATA_W = ((2 * COORD_WIDTH + nnpo_pkg::SRC_IDX_W + 7) / 8) * 8
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [nnpo_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [COORD_WIDTH-1:0]         cfg_data_i,
  input  wire logic                           s_axis_tvalid,
  output logic                                s_axis_tready,
  // point_x, point_y
  input  wire logic [IN_DATA_W-1:0]           s_axis_tdata,
  input  wire logic                           s_axis_tlast,
  output logic                                m_axis_tvalid,
  input  wire logic                           m_axis_tready,
  // out_x, out_y, source_index
  output logic [OUT_DATA_W-1:0]               m_axis_tdata,
  // overflowed
  output logic                                m_axis_tuser,
  output logic                                m_axis_tlast
);
  import nnpo_pkg::*;

  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1);
  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;

  nnpo_cmd_t              cmd;
  nnpo_status_t           status;
  logic [IDX_W-1:0]       issue_idx;
  logic [CNT_W-1:0]       count;
  logic [COORD_WIDTH-1:0] out_x, out_y;
  logic [SRC_IDX_W-1:0]   out_idx;

  nnpo_ctrl #(
    .MAX_POINTS (MAX_POINTS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_last_i   (s_axis_tlast),
    .in_ready_o  (s_axis_tready),
    .count_i     (count),
    .status_i    (status),
    .cmd_o       (cmd),
    .issue_idx_o (issue_idx)
  );

  nnpo_dp #(
    .MAX_POINTS  (MAX_POINTS),
    .COORD_WIDTH (COORD_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_x_i      (s_axis_tdata[COORD_WIDTH-1:0]),
    .in_y_i      (s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]),
    .cmd_i       (cmd),
    .issue_idx_i (issue_idx),
    .status_o    (status),
    .count_o     (count),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_x_o     (out_x),
    .out_y_o     (out_y),
    .out_idx_o   (out_idx),
    .out_ovf_o   (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_DATA_W'({out_idx, out_y, out_x});

endmodule
`default_nettype wire

@@ design/nnpo_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nnpo_ctrl
// controller: load phase, one scan over the point memory per emitted point,
// pipeline drain and result hand-off
// ----------------------------------------------------------------------------
module nnpo_ctrl #(
  parameter int unsigned MAX_POINTS = nnpo_pkg::MAX_POINTS_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1),
  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_last_i,
  output logic                      in_ready_o,
  input  wire logic [CNT_W-1:0]     count_i,
  input  nnpo_pkg::nnpo_status_t    status_i,
  output nnpo_pkg::nnpo_cmd_t       cmd_o,
  output logic [IDX_W-1:0]          issue_idx_o
);
  import nnpo_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] scan_q, scan_d;
  logic [CNT_W-1:0] emit_cnt_q, emit_cnt_d;
  logic [CNT_W-1:0] count_last;

  assign count_last  = count_i - CNT_W'(1);
  assign issue_idx_o = scan_q[IDX_W-1:0];

  always_comb begin
    state_d    = state_q;
    scan_d     = scan_q;
    emit_cnt_d = emit_cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          if (in_last_i) begin
            cmd_o.start_pass = 1'b1;
            scan_d           = '0;
            emit_cnt_d       = '0;
            state_d          = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd_o.issue = 1'b1;
        scan_d      = scan_q + CNT_W'(1);
        if (scan_q == count_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (emit_cnt_q == count_last) begin
            cmd_o.emit_last = 1'b1;
            state_d         = ST_IDLE;
          end else begin
            emit_cnt_d = emit_cnt_q + CNT_W'(1);
            scan_d     = '0;
            state_d    = ST_SCAN;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      scan_q     <= '0;
      emit_cnt_q <= '0;
    end else begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      emit_cnt_q <= emit_cnt_d;
    end
  end

  property p_issue_in_range;
    @(posedge clk_i) disable iff (!rst_ni)
      cmd_o.issue |-> (scan_q < count_i);
  endproperty
  a_issue_in_range: assert property (p_issue_in_range)
    else $error("scan index past point count");

  property p_emit_after_drain;
    @(posedge clk_i) disable iff (!rst_ni)
      cmd_o.emit |-> !status_i.pipe_busy;
  endproperty
  a_emit_after_drain: assert property (p_emit_after_drain)
    else $error("emit while distance pipeline busy");

  property p_last_ends_pass;
    @(posedge clk_i) disable iff (!rst_ni)
      cmd_o.emit_last |=> (state_q == ST_IDLE);
  endproperty
  a_last_ends_pass: assert property (p_last_ends_pass)
    else $error("pass did not end after final result");

endmodule
`default_nettype wire

@@ design/nnpo_dp.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// nnpo_dp
// datapath: point memory, visited marks, squared distance pipeline,
// best candidate tracking and result register
// ----------------------------------------------------------------------------
module nnpo_dp #(
  parameter int unsigned MAX_POINTS  = nnpo_pkg::MAX_POINTS_DEF,
  parameter int unsigned COORD_WIDTH = nnpo_pkg::COORD_WIDTH_DEF,
  localparam int unsigned CNT_W = $clog2(MAX_POINTS + 1),
  localparam int unsigned IDX_W = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [nnpo_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [COORD_WIDTH-1:0]            cfg_data_i,
  input  wire logic [COORD_WIDTH-1:0]            in_x_i,
  input  wire logic [COORD_WIDTH-1:0]            in_y_i,
  input  nnpo_pkg::nnpo_cmd_t                    cmd_i,
  input  wire logic [IDX_W-1:0]                  issue_idx_i,
  output nnpo_pkg::nnpo_status_t                 status_o,
  output logic [CNT_W-1:0]                       count_o,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic [COORD_WIDTH-1:0]                 out_x_o,
  output logic [COORD_WIDTH-1:0]                 out_y_o,
  output logic [nnpo_pkg::SRC_IDX_W-1:0]         out_idx_o,
  output logic                                   out_ovf_o,
  output logic                                   out_last_o
);
  import nnpo_pkg::*;

  localparam int unsigned CW = COORD_WIDTH;
  localparam int unsigned SW = 2 * COORD_WIDTH;
  localparam int unsigned DW = 2 * COORD_WIDTH + 1;

  // configuration and pass state
  logic [CW-1:0]         start_x_q, start_y_q;
  logic [CW-1:0]         cur_x_q, cur_y_q;
  logic [CNT_W-1:0]      count_q;
  logic                  ovf_q;
  logic [MAX_POINTS-1:0] visited_q;

  // point memory, y in the upper half
  logic [SW-1:0]         mem [MAX_POINTS];
  logic                  load_store;

  // distance pipeline
  logic                  p1_vld_q, p2_vld_q, p3_vld_q, p4_vld_q;
  logic [IDX_W-1:0]      p1_idx_q, p2_idx_q, p3_idx_q, p4_idx_q;
  logic [SW-1:0]         p1_pt_q, p2_pt_q, p3_pt_q, p4_pt_q;
  logic [CW:0]           dx, dy;
  logic [CW-1:0]         adx, ady;
  logic [CW-1:0]         adx_q, ady_q;
  logic [SW-1:0]         sqx_q, sqy_q;
  logic [DW-1:0]         dist_q;

  // best candidate
  logic                  found_q;
  logic [DW-1:0]         best_d_q;
  logic [IDX_W-1:0]      best_idx_q;
  logic [SW-1:0]         best_pt_q;
  logic                  take_best;

  // result register
  logic                  out_vld_q;
  logic [SW-1:0]         out_pt_q;
  logic [IDX_W-1:0]      out_idx_q;
  logic                  out_ovf_q, out_last_q;

  assign load_store = cmd_i.load && (count_q < CNT_W'(MAX_POINTS));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_x_q <= '0;
      start_y_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_START_X: start_x_q <= cfg_data_i;
        REG_START_Y: start_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      ovf_q     <= 1'b0;
      visited_q <= '0;
      cur_x_q   <= '0;
      cur_y_q   <= '0;
    end else begin
      if (cmd_i.load) begin
        if (load_store) begin
          count_q <= count_q + CNT_W'(1);
        end else begin
          ovf_q <= 1'b1;
        end
      end
      if (cmd_i.start_pass) begin
        visited_q <= '0;
        cur_x_q   <= start_x_q;
        cur_y_q   <= start_y_q;
      end
      if (cmd_i.emit) begin
        visited_q[best_idx_q] <= 1'b1;
        cur_x_q               <= best_pt_q[CW-1:0];
        cur_y_q               <= best_pt_q[SW-1:CW];
        if (cmd_i.emit_last) begin
          count_q <= '0;
          ovf_q   <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_store) begin
      mem[count_q[IDX_W-1:0]] <= {in_y_i, in_x_i};
    end
    p1_pt_q <= mem[issue_idx_i];
  end

  // signed difference and magnitude, magnitude always fits CW bits
  assign dx  = {p1_pt_q[CW-1], p1_pt_q[CW-1:0]} - {cur_x_q[CW-1], cur_x_q};
  assign dy  = {p1_pt_q[SW-1], p1_pt_q[SW-1:CW]} - {cur_y_q[CW-1], cur_y_q};
  assign adx = dx[CW] ? CW'(~dx + (CW+1)'(1)) : dx[CW-1:0];
  assign ady = dy[CW] ? CW'(~dy + (CW+1)'(1)) : dy[CW-1:0];

  assign take_best = p4_vld_q && (!found_q || (dist_q < best_d_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_vld_q <= 1'b0;
      p2_vld_q <= 1'b0;
      p3_vld_q <= 1'b0;
      p4_vld_q <= 1'b0;
      found_q  <= 1'b0;
    end else begin
      p1_vld_q <= cmd_i.issue && !visited_q[issue_idx_i];
      p2_vld_q <= p1_vld_q;
      p3_vld_q <= p2_vld_q;
      p4_vld_q <= p3_vld_q;
      if (cmd_i.emit) begin
        found_q <= 1'b0;
      end else if (take_best) begin
        found_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    p1_idx_q <= issue_idx_i;
    p2_idx_q <= p1_idx_q;
    p3_idx_q <= p2_idx_q;
    p4_idx_q <= p3_idx_q;
    p2_pt_q  <= p1_pt_q;
    p3_pt_q  <= p2_pt_q;
    p4_pt_q  <= p3_pt_q;
    adx_q    <= adx;
    ady_q    <= ady;
    sqx_q    <= SW'(adx_q) * SW'(adx_q);
    sqy_q    <= SW'(ady_q) * SW'(ady_q);
    dist_q   <= DW'(sqx_q) + DW'(sqy_q);
    if (take_best) begin
      best_d_q   <= dist_q;
      best_idx_q <= p4_idx_q;
      best_pt_q  <= p4_pt_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_pt_q   <= best_pt_q;
      out_idx_q  <= best_idx_q;
      out_ovf_q  <= ovf_q;
      out_last_q <= cmd_i.emit_last;
    end
  end

  assign status_o.pipe_busy = p1_vld_q || p2_vld_q || p3_vld_q || p4_vld_q;
  assign status_o.out_free  = !out_vld_q || out_ready_i;
  assign count_o            = count_q;

  assign out_valid_o = out_vld_q;
  assign out_x_o     = out_pt_q[CW-1:0];
  assign out_y_o     = out_pt_q[SW-1:CW];
  assign out_idx_o   = SRC_IDX_W'(out_idx_q);
  assign out_ovf_o   = out_ovf_q;
  assign out_last_o  = out_last_q;

  property p_emit_has_best;
    @(posedge clk_i) disable iff (!rst_ni)
      cmd_i.emit |-> found_q;
  endproperty
  a_emit_has_best: assert property (p_emit_has_best)
    else $error("emit without a candidate");

  property p_count_bound;
    @(posedge clk_i) disable iff (!rst_ni)
      count_q <= CNT_W'(MAX_POINTS);
  endproperty
  a_count_bound: assert property (p_count_bound)
    else $error("point count above capacity");

  property p_emit_fills_out;
    @(posedge clk_i) disable iff (!rst_ni)
      cmd_i.emit |=> out_vld_q;
  endproperty
  a_emit_fills_out: assert property (p_emit_fills_out)
    else $error("emitted result not held in output register");

  property p_no_load_in_pass;
    @(posedge clk_i) disable iff (!rst_ni)
      cmd_i.load |-> !status_o.pipe_busy && !found_q;
  endproperty
  a_no_load_in_pass: assert property (p_no_load_in_pass)
    else $error("load during ordering pass");

endmodule
`default_nettype wire
